FILE: rtl/sae_pkg.sv
// sae_pkg: shared types and constants for the suffix automaton extend block
// no dependencies
`default_nettype none
package sae_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_WCHK,
    ST_RDQ,
    ST_QCHK,
    ST_CLW,
    ST_QW,
    ST_RFIX,
    ST_RRD,
    ST_RCHK,
    ST_FIN
  } state_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/sae_ram.sv
// sae_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module sae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/sae_row.sv
// sae_row: selects one transition of a row and builds the row with it replaced
// no dependencies
`default_nettype none
module sae_row #(
  parameter int N    = 26,
  parameter int EW   = 11,
  parameter int SELW = 5
) (
  input  wire logic [N*EW-1:0] row_i,
  input  wire logic [SELW-1:0] sel_i,
  input  wire logic [EW-1:0]   val_i,
  output logic      [EW-1:0]   entry_o,
  output logic      [N*EW-1:0] row_upd_o
);

  always_comb begin
    entry_o   = '0;
    row_upd_o = row_i;
    for (int i = 0; i < N; i++) begin
      if (sel_i == SELW'(i)) begin
        entry_o                = row_i[i*EW +: EW];
        row_upd_o[i*EW +: EW]  = val_i;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/suffix_automaton_extend_core.sv
// suffix_automaton_extend_core: online suffix automaton construction, one symbol per beat
// depends on sae_pkg, sae_ram, sae_row
//
// usage
//   input channel: symbol_i with in_valid_i / in_ready_o, one symbol per beat
//   output channel: status_o, new_state_o, new_length_o, suffix_link_o, cloned_o,
//   clone_state_o with out_valid_o / out_ready_i, one result beat per input beat
//   all state of a node (transition row, suffix link, length) sits in one ram word,
//   so every step of the sequencer is one access of that ram
//   steps: per suffix link visited while adding transitions, read the node and check it;
//   then read and check the target state; to create a clone, write the clone, relink
//   the target and redirect the first transition; per further suffix link checked for
//   redirect, read and check it; last, store the new state
//   one symbol in flight; in_ready_o is low while a symbol is worked on or while
//   a result beat waits for out_ready_i, so a stalled receiver holds the input
//   reset: in the ST_INIT state after reset the root node is written with an empty row
//   and no suffix link; in_ready_o stays low in that state
//   symbols out of range, or when fewer than two free states or no text room
//   remain, give status 1 with all other fields zero and change nothing
`default_nettype none
module suffix_automaton_extend_core #(
  parameter int MAX_CHARS = 1024,
  parameter int ALPHABET  = 26
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [4:0]  symbol_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             status_o,
  output logic [10:0]      new_state_o,
  output logic [10:0]      new_length_o,
  output logic [10:0]      suffix_link_o,
  output logic             cloned_o,
  output logic [10:0]      clone_state_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);
  import sae_pkg::*;

  // derived sizes
  localparam int STATES = 2 * MAX_CHARS;
  localparam int SW     = $clog2(STATES);          // state index
  localparam int CNTW   = $clog2(STATES + 1);      // state count
  localparam int LW     = $clog2(MAX_CHARS + 1);   // length
  localparam int CW     = $clog2(ALPHABET);        // symbol index
  localparam int SYMW   = ((CW > 5) ? CW : 5) + 1; // range check width
  localparam int ROWW   = ALPHABET * SW;
  // ram word: {row, link none flag, link, length}
  localparam int WORDW  = ROWW + 1 + SW + LW;
  localparam int NONE_B = LW + SW;

  state_e state_q, state_d;

  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]    last_q, last_d;
  logic [LW-1:0]    last_len_q, last_len_d;
  logic [CW-1:0]    sym_q, sym_d;
  logic [SW-1:0]    r_q, r_d;
  logic [LW-1:0]    rlen_q, rlen_d;
  logic [SW-1:0]    p_q, p_d;
  logic [SW-1:0]    qs_q, qs_d;
  logic [LW-1:0]    lenp_q, lenp_d;
  logic [SW-1:0]    cl_q, cl_d;
  logic [SW-1:0]    link_q, link_d;
  logic             cloned_q, cloned_d;
  logic [WORDW-1:0] wp_q, wp_d;
  logic [WORDW-1:0] wq_q, wq_d;

  logic             out_valid_q, out_valid_d;
  logic             status_q, status_d;
  logic [10:0]      o_state_q, o_state_d;
  logic [10:0]      o_len_q, o_len_d;
  logic [10:0]      o_link_q, o_link_d;
  logic             o_cloned_q, o_cloned_d;
  logic [10:0]      o_clone_q, o_clone_d;

  // ram port
  logic             we;
  logic [SW-1:0]    waddr;
  logic [WORDW-1:0] wdata;
  logic [SW-1:0]    raddr;
  logic [WORDW-1:0] rdata;

  // fields of the word just read
  logic [ROWW-1:0]  rd_row;
  logic             rd_none;
  logic [SW-1:0]    rd_link;
  logic [LW-1:0]    rd_len;

  // row units
  logic [SW-1:0]    rd_val;
  logic [SW-1:0]    rd_entry;
  logic [ROWW-1:0]  rd_row_upd;
  logic [SW-1:0]    wp_entry;
  logic [ROWW-1:0]  wp_row_upd;

  logic [SYMW-1:0]  sym_ext;
  logic             refuse;
  logic             in_fire;

  assign rd_row  = rdata[WORDW-1 -: ROWW];
  assign rd_none = rdata[NONE_B];
  assign rd_link = rdata[LW +: SW];
  assign rd_len  = rdata[LW-1:0];

  assign sym_ext = SYMW'(symbol_i);
  assign refuse  = (sym_ext >= SYMW'(ALPHABET)) || (cnt_q > CNTW'(STATES - 2))
                || (last_len_q >= LW'(MAX_CHARS));

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // transitions added point at the new state, redirects at the clone
  assign rd_val = (state_q == ST_RCHK) ? cl_q : r_q;

  sae_ram #(
    .WIDTH (WORDW),
    .DEPTH (STATES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sae_row #(
    .N    (ALPHABET),
    .EW   (SW),
    .SELW (CW)
  ) u_row_rd (
    .row_i     (rd_row),
    .sel_i     (sym_q),
    .val_i     (rd_val),
    .entry_o   (rd_entry),
    .row_upd_o (rd_row_upd)
  );

  sae_row #(
    .N    (ALPHABET),
    .EW   (SW),
    .SELW (CW)
  ) u_row_wp (
    .row_i     (wp_q[WORDW-1 -: ROWW]),
    .sel_i     (sym_q),
    .val_i     (cl_q),
    .entry_o   (wp_entry),
    .row_upd_o (wp_row_upd)
  );

  // sequencer next state and working registers
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    last_len_d  = last_len_q;
    sym_d       = sym_q;
    r_d         = r_q;
    rlen_d      = rlen_q;
    p_d         = p_q;
    qs_d        = qs_q;
    lenp_d      = lenp_q;
    cl_d        = cl_q;
    link_d      = link_q;
    cloned_d    = cloned_q;
    wp_d        = wp_q;
    wq_d        = wq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    o_state_d   = o_state_q;
    o_len_d     = o_len_q;
    o_link_d    = o_link_q;
    o_cloned_d  = o_cloned_q;
    o_clone_d   = o_clone_q;

    case (state_q)
      ST_INIT: begin
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (refuse) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_FULL;
            o_state_d   = '0;
            o_len_d     = '0;
            o_link_d    = '0;
            o_cloned_d  = 1'b0;
            o_clone_d   = '0;
          end else begin
            sym_d      = sym_ext[CW-1:0];
            r_d        = cnt_q[SW-1:0];
            cnt_d      = cnt_q + CNTW'(1);
            rlen_d     = last_len_q + LW'(1);
            p_d        = last_q;
            last_d     = cnt_q[SW-1:0];
            last_len_d = last_len_q + LW'(1);
            cloned_d   = 1'b0;
            cl_d       = '0;
            state_d    = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_WCHK;
      end
      ST_WCHK: begin
        if (rd_entry == '0) begin
          if (rd_none) begin
            link_d  = '0;
            state_d = ST_FIN;
          end else begin
            p_d     = rd_link;
            state_d = ST_RD;
          end
        end else begin
          qs_d    = rd_entry;
          lenp_d  = rd_len;
          wp_d    = rdata;
          state_d = ST_RDQ;
        end
      end
      ST_RDQ: begin
        state_d = ST_QCHK;
      end
      ST_QCHK: begin
        if (rd_len == lenp_q + LW'(1)) begin
          link_d  = qs_q;
          state_d = ST_FIN;
        end else begin
          wq_d     = rdata;
          cl_d     = cnt_q[SW-1:0];
          cnt_d    = cnt_q + CNTW'(1);
          cloned_d = 1'b1;
          link_d   = cnt_q[SW-1:0];
          state_d  = ST_CLW;
        end
      end
      ST_CLW: begin
        state_d = ST_QW;
      end
      ST_QW: begin
        state_d = ST_RFIX;
      end
      ST_RFIX: begin
        if (wp_q[NONE_B]) begin
          state_d = ST_FIN;
        end else begin
          p_d     = wp_q[LW +: SW];
          state_d = ST_RRD;
        end
      end
      ST_RRD: begin
        state_d = ST_RCHK;
      end
      ST_RCHK: begin
        if (rd_entry == qs_q) begin
          if (rd_none) begin
            state_d = ST_FIN;
          end else begin
            p_d     = rd_link;
            state_d = ST_RRD;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        out_valid_d = 1'b1;
        status_d    = STATUS_OK;
        o_state_d   = 11'(r_q);
        o_len_d     = 11'(rlen_q);
        o_link_d    = 11'(link_q);
        o_cloned_d  = cloned_q;
        o_clone_d   = 11'(cl_q);
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ram accesses per sequencer state
  always_comb begin
    we    = 1'b0;
    waddr = p_q;
    wdata = rdata;
    raddr = p_q;
    case (state_q)
      ST_INIT: begin
        // root: empty row, no suffix link, length zero
        we    = 1'b1;
        waddr = '0;
        wdata = {{ROWW{1'b0}}, 1'b1, {SW{1'b0}}, {LW{1'b0}}};
      end
      ST_WCHK: begin
        we    = (rd_entry == '0);
        waddr = p_q;
        wdata = {rd_row_upd, rdata[NONE_B:0]};
      end
      ST_RDQ: begin
        raddr = qs_q;
      end
      ST_CLW: begin
        we    = 1'b1;
        waddr = cl_q;
        wdata = {wq_q[WORDW-1:LW], lenp_q + LW'(1)};
      end
      ST_QW: begin
        we    = 1'b1;
        waddr = qs_q;
        wdata = {wq_q[WORDW-1 -: ROWW], 1'b0, cl_q, wq_q[LW-1:0]};
      end
      ST_RFIX: begin
        we    = 1'b1;
        waddr = p_q;
        wdata = {wp_row_upd, wp_q[NONE_B:0]};
      end
      ST_RCHK: begin
        we    = (rd_entry == qs_q);
        waddr = p_q;
        wdata = {rd_row_upd, rdata[NONE_B:0]};
      end
      ST_FIN: begin
        we    = 1'b1;
        waddr = r_q;
        wdata = {{ROWW{1'b0}}, 1'b0, link_q, rlen_q};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= CNTW'(1);
      last_q      <= '0;
      last_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      last_len_q  <= last_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    r_q        <= r_d;
    rlen_q     <= rlen_d;
    p_q        <= p_d;
    qs_q       <= qs_d;
    lenp_q     <= lenp_d;
    cl_q       <= cl_d;
    link_q     <= link_d;
    cloned_q   <= cloned_d;
    wp_q       <= wp_d;
    wq_q       <= wq_d;
    status_q   <= status_d;
    o_state_q  <= o_state_d;
    o_len_q    <= o_len_d;
    o_link_q   <= o_link_d;
    o_cloned_q <= o_cloned_d;
    o_clone_q  <= o_clone_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign new_state_o   = o_state_q;
  assign new_length_o  = o_len_q;
  assign suffix_link_o = o_link_q;
  assign cloned_o      = o_cloned_q;
  assign clone_state_o = o_clone_q;

`ifndef SYNTHESIS
  // one symbol in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // a clone is always allocated right after the new state
  a_clone_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cloned_o) |-> (clone_state_o == new_state_o + 11'd1))
    else $error("clone index does not follow new state");

  // refused symbols carry no state information
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_FULL) |-> (new_state_o == 11'd0 && !cloned_o))
    else $error("refused beat carries state fields");

  // the redirect starts at the transition that led to the split state
  a_redirect_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RFIX) |-> (wp_entry == qs_q))
    else $error("redirect does not start at the split transition");
`endif

endmodule
`default_nettype wire
